[rtl/ptu_pkg.sv]
// Shared types, constants and arithmetic helpers of the particle table.
package ptu_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int BURST_W = 7;
  localparam int SUM_W = ((CNT_W > BURST_W) ? CNT_W : BURST_W) + 1;

  localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
  localparam logic [31:0] LFSR_MASK = 32'h80200003;
  localparam logic signed [31:0] TENTH_Q16 = 32'sd6554;
  localparam logic signed [16:0] HALF_RANGE = 17'sd32768;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_BURST = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_GRAVITY      = 2'd0,
    REG_SPEED_SCALE  = 2'd1,
    REG_MAX_AGE      = 2'd2,
    REG_POINT_RADIUS = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        time_step;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] vel_x_in;
    logic signed [31:0] vel_y_in;
    logic signed [31:0] vel_z_in;
    logic [6:0]         burst_count;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        out_radius;
    logic               present;
    logic               accepted;
    logic               last;
  } out_t;

  // One table entry.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] ay;
    logic [31:0]        age;
  } ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             ld_in;
    logic             k_mul;
    logic             k_sat;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             mul;
    logic             wr_upd;
    logic             wr_add;
    logic             burst;
    logic [IDX_W-1:0] wr_addr;
    logic             out_ld;
    logic             out_present;
    logic             out_accepted;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic survive;
  } sts_t;

  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    logic [31:0] r;
    r = s >> 1;
    if (s[0]) r = r ^ LFSR_MASK;
    return r;
  endfunction

  // Burst velocity from the upper half of the generator state.
  function automatic logic signed [31:0] draw_vel(input logic [31:0] s);
    logic signed [16:0] d;
    logic signed [31:0] p;
    d = $signed({1'b0, s[31:16]}) - HALF_RANGE;
    p = 32'(d) * TENTH_Q16;
    return p >>> 16;
  endfunction

  // base + floor(+-p / 2^16), saturated to the signed 32-bit range.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                 input logic neg, input logic [63:0] p);
    logic signed [64:0] s;
    logic signed [65:0] sum;
    s = neg ? -$signed({1'b0, p}) : $signed({1'b0, p});
    sum = 66'(base) + 66'(s >>> 16);
    if (sum > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (sum < -66'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

endpackage

[rtl/ptu_dp.sv]
// Datapath: registers, particle memory, step arithmetic and output register.
module ptu_dp import ptu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  in_t         in_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o
);

  logic [31:0] gravity_q, speed_q, max_age_q, radius_q;
  logic [31:0] lfsr_q, lfsr_d;
  in_t         in_q;
  ent_t        mem_q [MAX_PARTICLES];
  ent_t        rd_q, wdata;
  logic        we;
  logic [63:0] kprod_q;
  logic [31:0] k_q;
  logic [63:0] pvx_q, pvy_q, pvz_q, pay_q;
  logic        nvx_q, nvy_q, nvz_q, nay_q;
  logic [31:0] age_q;
  logic [32:0] age_sum;
  logic        out_valid_q;
  out_t        out_q;
  logic [31:0] draw1, draw2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= '0;
      speed_q   <= 32'h0001_0000;
      max_age_q <= '0;
      radius_q  <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_GRAVITY:      gravity_q <= cfg_data_i;
        REG_SPEED_SCALE:  speed_q   <= cfg_data_i;
        REG_MAX_AGE:      max_age_q <= cfg_data_i;
        REG_POINT_RADIUS: radius_q  <= cfg_data_i;
        default:          gravity_q <= gravity_q;
      endcase
    end
  end

  assign draw1 = lfsr_step(lfsr_q);
  assign draw2 = lfsr_step(draw1);
  assign lfsr_d = (cmd_i.wr_add && cmd_i.burst) ? draw2 : lfsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q      <= LFSR_SEED;
      out_valid_q <= 1'b0;
    end else begin
      lfsr_q <= lfsr_d;
      if (cmd_i.out_ld) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign age_sum = {1'b0, rd_q.age} + {1'b0, in_q.time_step};

  always_comb begin
    wdata = '0;
    if (cmd_i.wr_add) begin
      wdata.px = in_q.start_x;
      wdata.py = in_q.start_y;
      wdata.pz = in_q.start_z;
      wdata.ay = gravity_q;
      wdata.age = '0;
      if (cmd_i.burst) begin
        wdata.vx = draw_vel(draw1);
        wdata.vy = TENTH_Q16;
        wdata.vz = draw_vel(draw2);
      end else begin
        wdata.vx = in_q.vel_x_in;
        wdata.vy = in_q.vel_y_in;
        wdata.vz = in_q.vel_z_in;
      end
    end else begin
      wdata.px = sat_add(rd_q.px, nvx_q, pvx_q);
      wdata.py = sat_add(rd_q.py, nvy_q, pvy_q);
      wdata.pz = sat_add(rd_q.pz, nvz_q, pvz_q);
      wdata.vx = rd_q.vx;
      wdata.vy = sat_add(rd_q.vy, nay_q, pay_q);
      wdata.vz = rd_q.vz;
      wdata.ay = rd_q.ay;
      wdata.age = age_q;
    end
  end

  assign sts_o.survive = (max_age_q == '0) || (age_q <= max_age_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign we = cmd_i.wr_add || (cmd_i.wr_upd && sts_o.survive);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) in_q <= in_data_i;
    if (we) mem_q[cmd_i.wr_addr] <= wdata;
    if (cmd_i.rd_en) rd_q <= mem_q[cmd_i.rd_addr];
    if (cmd_i.k_mul) kprod_q <= 64'(in_q.time_step) * 64'(speed_q);
    if (cmd_i.k_sat) k_q <= (kprod_q[63:48] != '0) ? '1 : kprod_q[47:16];
    if (cmd_i.mul) begin
      nvx_q <= rd_q.vx[31];
      nvy_q <= rd_q.vy[31];
      nvz_q <= rd_q.vz[31];
      nay_q <= rd_q.ay[31];
      // The 32-bit magnitude is taken unsigned, so the most negative value stays exact.
      pvx_q <= 64'($unsigned(rd_q.vx[31] ? -rd_q.vx : rd_q.vx)) * 64'(k_q);
      pvy_q <= 64'($unsigned(rd_q.vy[31] ? -rd_q.vy : rd_q.vy)) * 64'(k_q);
      pvz_q <= 64'($unsigned(rd_q.vz[31] ? -rd_q.vz : rd_q.vz)) * 64'(k_q);
      pay_q <= 64'($unsigned(rd_q.ay[31] ? -rd_q.ay : rd_q.ay)) * 64'(k_q);
      age_q <= age_sum[32] ? '1 : age_sum[31:0];
    end
    if (cmd_i.out_ld) begin
      out_q.present    <= cmd_i.out_present;
      out_q.accepted   <= cmd_i.out_accepted;
      out_q.last       <= cmd_i.out_last;
      out_q.out_x      <= cmd_i.out_present ? rd_q.px : '0;
      out_q.out_y      <= cmd_i.out_present ? rd_q.py : '0;
      out_q.out_z      <= cmd_i.out_present ? rd_q.pz : '0;
      out_q.out_radius <= cmd_i.out_present ? radius_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

[rtl/ptu_ctrl.sv]
// Controller state machine that sequences adds, tick updates and emission.
module ptu_ctrl import ptu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [BURST_W-1:0] burst_count_i,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_KMUL, S_KSAT, S_TRD, S_TMUL, S_TWR, S_ERD, S_EOUT, S_REPLY
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   live_q, i_q, w_q;
  logic [BURST_W-1:0] rem_q;
  logic               burst_q, acc_q;
  logic [SUM_W-1:0]   need;
  logic [CNT_W-1:0]   w_next;

  assign in_stall_o = (state_q != S_IDLE);
  assign need = SUM_W'(live_q) + SUM_W'(op_e'(op_i) == OP_ADD ? BURST_W'(1) : burst_count_i);
  assign w_next = w_q + CNT_W'(sts_i.survive);

  always_comb begin
    cmd_o = '0;
    cmd_o.burst = burst_q;
    case (state_q)
      S_IDLE: cmd_o.ld_in = in_valid_i;
      S_ADD: begin
        cmd_o.wr_add = 1'b1;
        cmd_o.wr_addr = live_q[IDX_W-1:0];
      end
      S_KMUL: cmd_o.k_mul = 1'b1;
      S_KSAT: cmd_o.k_sat = 1'b1;
      S_TRD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_addr = i_q[IDX_W-1:0];
      end
      S_TMUL: cmd_o.mul = 1'b1;
      S_TWR: begin
        cmd_o.wr_upd = 1'b1;
        cmd_o.wr_addr = w_q[IDX_W-1:0];
      end
      S_ERD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_addr = i_q[IDX_W-1:0];
      end
      S_EOUT: begin
        cmd_o.out_ld = sts_i.out_free;
        cmd_o.out_present = 1'b1;
        cmd_o.out_last = (i_q + CNT_W'(1) == live_q);
      end
      S_REPLY: begin
        cmd_o.out_ld = sts_i.out_free;
        cmd_o.out_accepted = acc_q;
        cmd_o.out_last = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      live_q  <= '0;
      i_q     <= '0;
      w_q     <= '0;
      rem_q   <= '0;
      burst_q <= 1'b0;
      acc_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            burst_q <= (op_e'(op_i) == OP_BURST);
            rem_q   <= (op_e'(op_i) == OP_ADD) ? BURST_W'(1) : burst_count_i;
            case (op_e'(op_i))
              OP_TICK: begin
                acc_q   <= 1'b0;
                state_q <= S_KMUL;
              end
              OP_ADD, OP_BURST: begin
                if (need > SUM_W'(MAX_PARTICLES)) begin
                  acc_q   <= 1'b0;
                  state_q <= S_REPLY;
                end else if (need == SUM_W'(live_q)) begin
                  acc_q   <= 1'b1;
                  state_q <= S_REPLY;
                end else begin
                  acc_q   <= 1'b0;
                  state_q <= S_ADD;
                end
              end
              default: begin
                acc_q   <= 1'b0;
                state_q <= S_REPLY;
              end
            endcase
          end
        end
        S_ADD: begin
          live_q <= live_q + CNT_W'(1);
          rem_q  <= rem_q - BURST_W'(1);
          if (rem_q == BURST_W'(1)) begin
            acc_q   <= 1'b1;
            state_q <= S_REPLY;
          end
        end
        S_KMUL: state_q <= S_KSAT;
        S_KSAT: begin
          i_q <= '0;
          w_q <= '0;
          state_q <= (live_q == '0) ? S_REPLY : S_TRD;
        end
        S_TRD: state_q <= S_TMUL;
        S_TMUL: state_q <= S_TWR;
        S_TWR: begin
          w_q <= w_next;
          if (i_q + CNT_W'(1) == live_q) begin
            live_q  <= w_next;
            i_q     <= '0;
            state_q <= (w_next == '0) ? S_REPLY : S_ERD;
          end else begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= S_TRD;
          end
        end
        S_ERD: state_q <= S_EOUT;
        S_EOUT: begin
          if (sts_i.out_free) begin
            i_q <= i_q + CNT_W'(1);
            state_q <= (i_q + CNT_W'(1) == live_q) ? S_IDLE : S_ERD;
          end
        end
        S_REPLY: if (sts_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/particle_table_euler_update.sv]
// Top level of the ordered particle table with a fixed-point Euler update.
// The block keeps up to 64 particles in insertion order in a single-port-write,
// registered-read memory and handles one request at a time. An add request
// writes one entry per cycle and replies with one result. A tick request
// first forms the scaled step in a multiply state and a saturate state, then
// runs each stored particle through a read, a multiply and a write-back
// step, compacting survivors in place, and then emits each survivor with a
// read and an output step. A result waits in an output register, and the next
// request is taken once the previous one's last result has been loaded there.
// Configuration writes take effect at the next clock edge; no clearing pass
// is needed after reset.
module particle_table_euler_update import ptu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // The controller owns the counters and the particle count.
  ptu_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (in_data_i.op),
    .burst_count_i (in_data_i.burst_count),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // The datapath holds the table, the generator and the output register.
  ptu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/ptu_checker.sv]
// Port-level checker for the particle table, bound to the top level.
module ptu_checker import ptu_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in progress");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.present && out_data_o.accepted))
    else $error("particle result flagged as add reply");

  a_reply_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.present |->
      out_data_o.last && out_data_o.out_x == '0 && out_data_o.out_radius == '0)
    else $error("reply result carries data or is not last");

endmodule

bind particle_table_euler_update ptu_checker u_ptu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
